// ----- design/afpt_pkg.sv -----
// Package for the audio frame pacing timer.
// Register map, reset values, widths and the structs passed between modules.
// No dependencies.
package afpt_pkg;

  // Default width of the wrapping microsecond time base
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int NOW_W     = 32;
  localparam int FRAMES_W  = 32;
  localparam int PERIOD_W  = 20;
  localparam int TIMEOUT_W = 24;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Register indexes (byte address is four times the index)
  localparam logic [1:0] REG_NORMAL_PERIOD = 2'd0;
  localparam logic [1:0] REG_FAST_PERIOD   = 2'd1;
  localparam logic [1:0] REG_MINIMUM_GAP   = 2'd2;
  localparam logic [1:0] REG_CATCHUP       = 2'd3;

  // Register reset values
  localparam logic [PERIOD_W-1:0]  NORMAL_PERIOD_RST = 20'd3000;
  localparam logic [PERIOD_W-1:0]  FAST_PERIOD_RST   = 20'd2900;
  localparam logic [PERIOD_W-1:0]  MINIMUM_GAP_RST   = 20'd1700;
  localparam logic [TIMEOUT_W-1:0] CATCHUP_RST       = 24'd216000;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [PERIOD_W-1:0]  normal_period_us;
    logic [PERIOD_W-1:0]  fast_period_us;
    logic [PERIOD_W-1:0]  minimum_gap_us;
    logic [TIMEOUT_W-1:0] catchup_timeout_us;
  } afpt_cfg_t;

  // Outcome of one check event
  typedef struct packed {
    logic period_taken;
    logic queue_frame;
    logic skipped_ahead;
  } afpt_res_t;

endpackage

// ----- design/audio_frame_pacing_timer.sv -----
// Top level of the audio frame pacing timer: input register, result register,
// configuration port. Depends on afpt_pkg, afpt_regs and afpt_core.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   input   | in_valid / in_stall   | now_us, need_more_blocks, engine_ready,
//           |                       | processed_frames
//   output  | out_valid / out_stall | period_taken, queue_frame, skipped_ahead
//   config  | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle unless the output stalls.
// The pacing decision and state update happen in one pass between the input
// register and the result register, so the next transaction sees updated marks.
// Reset is synchronous; all settings return to their defaults and the block
// restarts with the next check event. A stall on the output holds the result
// register, and input stalls only once the input register is also full.
module audio_frame_pacing_timer #(
  parameter int TIME_BITS = afpt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [afpt_pkg::NOW_W-1:0]     now_us,
  input  logic                           need_more_blocks,
  input  logic                           engine_ready,
  input  logic [afpt_pkg::FRAMES_W-1:0]  processed_frames,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           period_taken,
  output logic                           queue_frame,
  output logic                           skipped_ahead,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [afpt_pkg::PADDR_W-1:0]   paddr,
  input  logic [afpt_pkg::PDATA_W-1:0]   pwdata,
  output logic [afpt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import afpt_pkg::*;

  afpt_cfg_t           cfg;
  afpt_res_t           res;

  logic                hold_valid;
  logic [NOW_W-1:0]    hold_now_us;
  logic                hold_need_more_blocks;
  logic                hold_engine_ready;
  logic [FRAMES_W-1:0] hold_processed_frames;

  logic                advance;
  logic                step;
  logic                accept;

  // Pipeline flow
  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  afpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afpt_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .now_us           (hold_now_us),
    .need_more_blocks (hold_need_more_blocks),
    .engine_ready     (hold_engine_ready),
    .processed_frames (hold_processed_frames),
    .cfg              (cfg),
    .res              (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_now_us           <= now_us;
      hold_need_more_blocks <= need_more_blocks;
      hold_engine_ready     <= engine_ready;
      hold_processed_frames <= processed_frames;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      period_taken  <= res.period_taken;
      queue_frame   <= res.queue_frame;
      skipped_ahead <= res.skipped_ahead;
    end
  end

  // Input only backs up behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && hold_valid))
    else $error("input stalled without a blocked result");

  // A held transaction that moves on always lands in the result register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed transaction lost before the result register");

  // Result register never empties while its content is stalled
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(period_taken)))
    else $error("stalled result changed");

endmodule

// ----- design/afpt_regs.sv -----
// Configuration register file of the audio frame pacing timer (APB-style port).
// Depends on afpt_pkg.
module afpt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [afpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [afpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output afpt_pkg::afpt_cfg_t           cfg
);
  import afpt_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_period_us   <= NORMAL_PERIOD_RST;
      cfg.fast_period_us     <= FAST_PERIOD_RST;
      cfg.minimum_gap_us     <= MINIMUM_GAP_RST;
      cfg.catchup_timeout_us <= CATCHUP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NORMAL_PERIOD: cfg.normal_period_us   <= pwdata[PERIOD_W-1:0];
        REG_FAST_PERIOD:   cfg.fast_period_us     <= pwdata[PERIOD_W-1:0];
        REG_MINIMUM_GAP:   cfg.minimum_gap_us     <= pwdata[PERIOD_W-1:0];
        REG_CATCHUP:       cfg.catchup_timeout_us <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (reg_idx)
      REG_NORMAL_PERIOD: prdata = PDATA_W'(cfg.normal_period_us);
      REG_FAST_PERIOD:   prdata = PDATA_W'(cfg.fast_period_us);
      REG_MINIMUM_GAP:   prdata = PDATA_W'(cfg.minimum_gap_us);
      REG_CATCHUP:       prdata = PDATA_W'(cfg.catchup_timeout_us);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- design/afpt_core.sv -----
// Pacing decision and timing state of the audio frame pacing timer.
// Holds the interval mark, last-check mark and queued count. Depends on afpt_pkg.
module afpt_core #(
  parameter int TIME_BITS = afpt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [afpt_pkg::NOW_W-1:0]     now_us,
  input  logic                           need_more_blocks,
  input  logic                           engine_ready,
  input  logic [afpt_pkg::FRAMES_W-1:0]  processed_frames,
  input  afpt_pkg::afpt_cfg_t            cfg,
  output afpt_pkg::afpt_res_t            res
);
  import afpt_pkg::*;

  // Compare width covers both the time base and the widest setting
  localparam int CW = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  logic                 started;
  logic [TIME_BITS-1:0] interval_mark;
  logic [TIME_BITS-1:0] last_check_mark;
  logic [FRAMES_W-1:0]  queued_count;

  logic [63:0]          now_wide;
  logic [63:0]          normal_wide;
  logic [63:0]          period_wide;
  logic [PERIOD_W-1:0]  period;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] normal_t;
  logic [TIME_BITS-1:0] period_t;
  logic [TIME_BITS-1:0] mark_eff;
  logic [TIME_BITS-1:0] last_eff;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] gap;
  logic [CW-1:0]        diff_w;
  logic [CW-1:0]        gap_w;
  logic                 fire;
  logic                 skip;
  logic                 queue;
  logic [TIME_BITS-1:0] interval_mark_next;

  // Bring the time stamp and settings onto the time base
  assign period      = need_more_blocks ? cfg.fast_period_us : cfg.normal_period_us;
  assign now_wide    = {{(64-NOW_W){1'b0}}, now_us};
  assign normal_wide = {{(64-PERIOD_W){1'b0}}, cfg.normal_period_us};
  assign period_wide = {{(64-PERIOD_W){1'b0}}, period};
  assign now_t       = now_wide[TIME_BITS-1:0];
  assign normal_t    = normal_wide[TIME_BITS-1:0];
  assign period_t    = period_wide[TIME_BITS-1:0];

  // First event seeds both marks before the checks
  assign mark_eff = started ? interval_mark : (now_t - normal_t);
  assign last_eff = started ? last_check_mark : now_t;

  // Wrapping differences and the two wait checks
  assign diff   = now_t - mark_eff;
  assign gap    = now_t - last_eff;
  assign diff_w = CW'(diff);
  assign gap_w  = CW'(gap);
  assign fire   = (diff_w >= CW'(period)) && (gap_w >= CW'(cfg.minimum_gap_us));
  assign skip   = fire && (diff_w >= CW'(cfg.catchup_timeout_us));
  assign queue  = fire && engine_ready && (queued_count == processed_frames);

  // Mark either advances by one period or jumps past a long lag
  assign interval_mark_next = skip ? (now_t - period_t) : (mark_eff + period_t);

  assign res.period_taken  = fire;
  assign res.queue_frame   = queue;
  assign res.skipped_ahead = skip;

  // Timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      interval_mark   <= '0;
      last_check_mark <= '0;
      queued_count    <= '0;
    end else if (step) begin
      started         <= 1'b1;
      interval_mark   <= fire ? interval_mark_next : mark_eff;
      last_check_mark <= fire ? now_t : last_eff;
      if (queue) begin
        queued_count <= queued_count + 1'b1;
      end
    end
  end

  // A frame is only queued on a taken period
  a_queue_needs_fire: assert property (@(posedge clk) disable iff (rst)
    res.queue_frame |-> res.period_taken)
    else $error("frame queued without a taken period");

  // Skipping ahead is a kind of taken period
  a_skip_needs_fire: assert property (@(posedge clk) disable iff (rst)
    res.skipped_ahead |-> res.period_taken)
    else $error("skip ahead without a taken period");

  // Queued count moves by exactly one per queued frame
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    (step && queue) |=> (queued_count == $past(queued_count) + 1'b1))
    else $error("queued count did not advance by one");

endmodule

// ----- bench/tb_audio_frame_pacing_timer.sv -----
// Testbench for audio_frame_pacing_timer: directed and random check events, with
// results compared against a predictor of the pacing rules kept in this file.
// Depends on afpt_pkg and the design sources under design/.
module tb_audio_frame_pacing_timer;
  import afpt_pkg::*;

  // Clock, reset and block ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [NOW_W-1:0]    now_us = '0;
  logic                need_more_blocks = 1'b0;
  logic                engine_ready = 1'b0;
  logic [FRAMES_W-1:0] processed_frames = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                period_taken;
  logic                queue_frame;
  logic                skipped_ahead;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor copy of the settings and the pacing state
  logic [PERIOD_W-1:0]  cfg_normal = NORMAL_PERIOD_RST;
  logic [PERIOD_W-1:0]  cfg_fast = FAST_PERIOD_RST;
  logic [PERIOD_W-1:0]  cfg_gap = MINIMUM_GAP_RST;
  logic [TIMEOUT_W-1:0] cfg_catchup = CATCHUP_RST;
  logic                 pace_started = 1'b0;
  logic [31:0]          interval_mark = '0;
  logic [31:0]          last_fire_mark = '0;
  logic [31:0]          queued_total = '0;

  afpt_res_t   expected_outcomes[$];
  int          fault_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          hold_len = 0;
  logic [31:0] clock_us = '0;

  audio_frame_pacing_timer u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .now_us           (now_us),
    .need_more_blocks (need_more_blocks),
    .engine_ready     (engine_ready),
    .processed_frames (processed_frames),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .period_taken     (period_taken),
    .queue_frame      (queue_frame),
    .skipped_ahead    (skipped_ahead),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pacing decision for one check event; updates the predictor state
  function automatic afpt_res_t predict_pacing(input logic [31:0] now, input logic need,
                                               input logic ready, input logic [31:0] processed);
    afpt_res_t   res;
    logic [31:0] period;
    logic [31:0] lag;
    logic [31:0] since_fire;
    res = '0;
    // start-up: mark one normal period back, no gap credit yet
    if (!pace_started) begin
      interval_mark  = now - cfg_normal;
      last_fire_mark = now;
      pace_started   = 1'b1;
    end
    period     = need ? 32'(cfg_fast) : 32'(cfg_normal);
    lag        = now - interval_mark;
    since_fire = now - last_fire_mark;
    if (lag >= period && since_fire >= cfg_gap) begin
      res.period_taken = 1'b1;
      last_fire_mark   = now;
      if (lag >= cfg_catchup) begin
        interval_mark     = now - period;
        res.skipped_ahead = 1'b1;
      end else begin
        interval_mark = interval_mark + period;
      end
      if (ready && queued_total == processed) begin
        res.queue_frame = 1'b1;
        queued_total    = queued_total + 1;
      end
    end
    return res;
  endfunction

  // Time step for random events, scaled to the current settings
  function automatic logic [31:0] next_step_us();
    int unsigned base;
    base = 32'(cfg_normal);
    if (cfg_fast > base) base = 32'(cfg_fast);
    if (cfg_gap > base) base = 32'(cfg_gap);
    if (base == 0) base = 1;
    case ($urandom_range(9))
      0:          return 32'd0;
      1, 2:       return $urandom_range(base / 2);
      3, 4, 5, 6: return base - base / 8 + $urandom_range(base / 4);
      7:          return 2 * base + $urandom_range(base);
      8:          return cfg_catchup + $urandom_range(base);
      default:    return $urandom();
    endcase
  endfunction

  // Offer one check event and record its expected outcome once accepted
  task automatic send_event(input logic [31:0] now, input logic need, input logic ready,
                            input logic [31:0] processed);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    now_us           <= now;
    need_more_blocks <= need;
    engine_ready     <= ready;
    processed_frames <= processed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_outcomes.push_back(predict_pacing(now, need, ready, processed));
  endtask

  task automatic advance_and_send(input logic [31:0] step, input logic need, input logic ready,
                                  input logic [31:0] processed);
    clock_us = clock_us + step;
    send_event(clock_us, need, ready, processed);
  endtask

  // Mostly consistent frame counts so queueing happens, with some mismatches
  task automatic run_random(input int count);
    logic [31:0] processed;
    repeat (count) begin
      case ($urandom_range(7))
        0:       processed = $urandom();
        1:       processed = queued_total - 1;
        2:       processed = queued_total + 1;
        default: processed = queued_total;
      endcase
      advance_and_send(next_step_us(), 1'($urandom_range(1)), $urandom_range(7) != 0,
                       processed);
    end
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // Register write (setup + access), then read the value back
  task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    stored = (idx == REG_CATCHUP) ? (value & 32'h00FF_FFFF) : (value & 32'h000F_FFFF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_NORMAL_PERIOD: cfg_normal  = stored[PERIOD_W-1:0];
      REG_FAST_PERIOD:   cfg_fast    = stored[PERIOD_W-1:0];
      REG_MINIMUM_GAP:   cfg_gap     = stored[PERIOD_W-1:0];
      REG_CATCHUP:       cfg_catchup = stored[TIMEOUT_W-1:0];
      default: ;
    endcase
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      $error("prdata: expected %0h, got %0h", stored, prdata);
      fault_count++;
    end
    // bus idle before the next transfer
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] normal, input logic [31:0] fast,
                           input logic [31:0] gap, input logic [31:0] catchup);
    write_setting(REG_NORMAL_PERIOD, normal);
    write_setting(REG_FAST_PERIOD, fast);
    write_setting(REG_MINIMUM_GAP, gap);
    write_setting(REG_CATCHUP, catchup);
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin : receiver_stall
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    afpt_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with no check event pending");
        fault_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (period_taken !== want.period_taken) begin
          $error("period_taken: expected %0b, got %0b", want.period_taken, period_taken);
          fault_count++;
        end
        if (queue_frame !== want.queue_frame) begin
          $error("queue_frame: expected %0b, got %0b", want.queue_frame, queue_frame);
          fault_count++;
        end
        if (skipped_ahead !== want.skipped_ahead) begin
          $error("skipped_ahead: expected %0b, got %0b", want.skipped_ahead, skipped_ahead);
          fault_count++;
        end
      end
    end
  end

  // Start-up event, gap credit, and a timestamp wrap past zero
  task automatic test_first_event_and_wrap();
    set_idling(0, 0);
    clock_us = 32'hFFFF_F000;
    send_event(clock_us, 1'b0, 1'b1, queued_total);
    advance_and_send(1000, 1'b0, 1'b1, queued_total);
    advance_and_send(700, 1'b0, 1'b1, queued_total);
    advance_and_send(3000, 1'b0, 1'b1, queued_total);
    advance_and_send(2999, 1'b0, 1'b1, queued_total);
  endtask

  // Boundaries of both waits, fast and normal period, timestamp extremes
  task automatic test_wait_checks();
    advance_and_send(1699, 1'b0, 1'b1, queued_total);
    advance_and_send(1, 1'b0, 1'b1, queued_total);
    advance_and_send(2900, 1'b1, 1'b1, queued_total);
    advance_and_send(2899, 1'b1, 1'b1, queued_total);
    advance_and_send(3000, 1'b1, 1'b1, queued_total);
    clock_us = 32'hFFFF_FFFF;
    send_event(clock_us, 1'b0, 1'b1, queued_total);
    clock_us = 32'h0000_0000;
    send_event(clock_us, 1'b1, 1'b1, queued_total);
  endtask

  // Firing with and without queueing: engine not ready, counts disagree, counts agree
  task automatic test_queue_conditions();
    advance_and_send(3000, 1'b0, 1'b0, queued_total);
    advance_and_send(3000, 1'b0, 1'b1, queued_total + 1);
    advance_and_send(3000, 1'b1, 1'b1, 32'hFFFF_FFFF);
    advance_and_send(3000, 1'b0, 1'b1, 32'h0000_0000);
    advance_and_send(3000, 1'b0, 1'b1, queued_total);
  endtask

  // Lag past the catch-up timeout, including time running backwards
  task automatic test_skip_ahead();
    advance_and_send(250000, 1'b0, 1'b1, queued_total);
    advance_and_send(3000, 1'b1, 1'b1, queued_total);
    clock_us = clock_us - 5000;
    send_event(clock_us, 1'b0, 1'b1, queued_total);
    advance_and_send(216000, 1'b0, 1'b1, queued_total);
    advance_and_send(2000, 1'b0, 1'b1, queued_total);
  endtask

  // All-ones writes (masked to width) and all-zero settings
  task automatic test_register_extremes();
    drain();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(6);
    drain();
    write_all(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(6);
    drain();
  endtask

  // Long receiver hold-off while events keep coming, then a full pause
  task automatic test_full_stall();
    set_idling(0, 0);
    hold_len <= 300;
    hold_seq <= hold_seq + 1;
    run_random(40);
    drain();
  endtask

  // Random events over several settings and idling patterns
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase % 4)
        0: write_all(32'(NORMAL_PERIOD_RST), 32'(FAST_PERIOD_RST), 32'(MINIMUM_GAP_RST),
                     32'(CATCHUP_RST));
        1: write_all(40, 25, 10, 300);
        2: write_all(1000000, 999000, 600000, 16000000);
        default: write_all(3000, 2900, 0, 9000);
      endcase
      case ((phase + phase / 4) % 4)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(16, 16);
      endcase
      run_random(130);
    end
  endtask

  // Test sequence
  initial begin
    int wait_cycles;
    wait_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_event_and_wrap();
    test_wait_checks();
    test_queue_conditions();
    test_skip_ahead();
    test_register_extremes();
    test_full_stall();
    test_random_phases();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      fault_count++;
    end
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_audio_frame_pacing_timer: clean");
    end else begin
      $display("tb_audio_frame_pacing_timer: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 200000);
    $display("tb_audio_frame_pacing_timer: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/afpt_pkg.sv
design/afpt_regs.sv
design/afpt_core.sv
design/audio_frame_pacing_timer.sv
bench/tb_audio_frame_pacing_timer.sv
